/* hw/rtl/obvl_pkg.sv */
`timescale 1ns / 1ps

package obvl_pkg;

	// Register map
	localparam logic       REG_MAX_ADV   = 1'b0;
	localparam logic [10:0] MAX_ADV_RESET = 11'd300;

	// Road law constants
	localparam logic [15:0] DIST_NEAR   = 16'd500;
	localparam logic [17:0] CURV_K      = 18'd151278;   // 1.6*log2(e), Q16
	localparam logic [19:0] ROT_K       = 20'd725686;   // log2(100)/0.6, Q16
	localparam logic [16:0] FLOOR_TENTH = 17'd6554;     // 0.1 in Q16
	localparam logic [12:0] PROD_CLAMP  = 13'd4096;
	localparam logic [12:0] SPEED_LIMIT = 13'd2000;

	// Divider: 500<<16 over distance, restoring, 5 bits per stage
	localparam int          QW          = 25;
	localparam logic [24:0] DIV_NUM     = 25'd32768000;
	localparam int          DIV_STAGES  = 5;
	localparam int          DIV_STEPS   = 5;

	// 2^-x unit: one fraction bit per stage
	localparam int POW_STAGES = 16;

	// Item pipeline depth
	localparam int PIPE_DEPTH = 28;

	typedef struct packed {
		logic signed [13:0] rot;
		logic signed [15:0] dx;
		logic signed [15:0] dz;
		logic               abort_f;
	} side_t;

	// Integer square root, used only on constants
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = x_in;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (b > x) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^-(2^-k) in Q30
	function automatic logic [29:0] pow_fac(input int k);
		logic [63:0] c;
		c = 64'd1 << 29;
		for (int i = 1; i <= 16; i++) begin
			if (i <= k) c = isqrt64(c << 30);
		end
		return c[29:0];
	endfunction

	// Q16 multiply, round half up
	function automatic logic [26:0] mul_q16(input logic [26:0] a, input logic [16:0] b);
		logic [43:0] p;
		p = 44'(a) * 44'(b) + 44'd32768;
		return p[42:16];
	endfunction

	// modulus * |dir| >> 30, round half up
	function automatic logic [13:0] spd_mag(input logic [26:0] m, input logic signed [15:0] d);
		logic [15:0] mag;
		logic [43:0] p;
		mag = d[15] ? 16'(-d) : 16'(d);
		p = 44'(m) * 44'(mag) + (44'd1 << 29);
		return p[43:30];
	endfunction

	// Clamp, negate against the direction, saturate
	function automatic logic signed [11:0] spd_final(input logic [13:0] p,
		input logic signed [15:0] d);
		logic [12:0] c;
		c = (p > 14'(PROD_CLAMP)) ? PROD_CLAMP : p[12:0];
		if (c > SPEED_LIMIT) c = SPEED_LIMIT;
		return (!d[15] && d != 16'sd0) ? -$signed(12'(c)) : $signed(12'(c));
	endfunction

endpackage

/* hw/rtl/obvl_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider: DIV_NUM / den, quotient registered after the last stage
module obvl_div (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] den,
	output logic [24:0] quot
);

	logic [15:0] rem_s [1:obvl_pkg::DIV_STAGES];
	logic [24:0] q_s   [1:obvl_pkg::DIV_STAGES];
	logic [15:0] d_s   [1:obvl_pkg::DIV_STAGES];

	for (genvar g = 1; g <= obvl_pkg::DIV_STAGES; g++) begin : g_stage
		logic [15:0] rem_in;
		logic [24:0] q_in;
		logic [15:0] d_in;
		logic [15:0] rem_nx;
		logic [24:0] q_nx;

		if (g == 1) begin : g_first
			assign rem_in = '0;
			assign q_in   = '0;
			assign d_in   = den;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign q_in   = q_s[g-1];
			assign d_in   = d_s[g-1];
		end

		// a few compare-subtract steps
		always_comb begin : c_steps
			logic [16:0] t;
			rem_nx = rem_in;
			q_nx   = q_in;
			for (int j = 0; j < obvl_pkg::DIV_STEPS; j++) begin
				t = {rem_nx, obvl_pkg::DIV_NUM[obvl_pkg::QW-1-obvl_pkg::DIV_STEPS*(g-1)-j]};
				if (t >= {1'b0, d_in}) begin
					t = t - {1'b0, d_in};
					q_nx[obvl_pkg::QW-1-obvl_pkg::DIV_STEPS*(g-1)-j] = 1'b1;
				end
				rem_nx = t[15:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nx;
				q_s[g]   <= q_nx;
				d_s[g]   <= d_in;
			end
		end
	end

	assign quot = q_s[obvl_pkg::DIV_STAGES];

endmodule

/* hw/rtl/obvl_pow2.sv */
`timescale 1ns / 1ps

// 2^-x, x in Q16, y in Q16; one fraction bit per stage, then a registered integer shift
module obvl_pow2 (
	input  logic        clk,
	input  logic        en,
	input  logic [24:0] x,
	output logic [16:0] y
);

	logic [30:0] r_s [1:obvl_pkg::POW_STAGES];
	logic [15:0] f_s [1:obvl_pkg::POW_STAGES-1];
	logic [8:0]  n_s [1:obvl_pkg::POW_STAGES];
	logic [16:0] y_q;
	logic [16:0] y_nx;

	for (genvar g = 1; g <= obvl_pkg::POW_STAGES; g++) begin : g_stage
		localparam logic [29:0] CF = obvl_pkg::pow_fac(g);
		logic [30:0] r_in;
		logic [15:0] f_in;
		logic [8:0]  n_in;
		logic [60:0] prod;

		if (g == 1) begin : g_first
			assign r_in = 31'd1 << 30;
			assign f_in = x[15:0];
			assign n_in = x[24:16];
		end else begin : g_next
			assign r_in = r_s[g-1];
			assign f_in = f_s[g-1];
			assign n_in = n_s[g-1];
		end

		assign prod = 61'(r_in) * 61'(CF);

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[g] <= f_in[obvl_pkg::POW_STAGES-g] ? prod[60:30] : r_in;
				n_s[g] <= n_in;
			end
		end

		if (g < obvl_pkg::POW_STAGES) begin : g_frac
			always_ff @(posedge clk) begin
				if (en) f_s[g] <= f_in;
			end
		end
	end

	// integer part: rounded right shift by 14+n, zero beyond 31
	always_comb begin : c_shift
		logic [5:0]  sh;
		logic [45:0] sum;
		sh   = 6'd14 + 6'(n_s[obvl_pkg::POW_STAGES][4:0]);
		sum  = 46'(r_s[obvl_pkg::POW_STAGES]) + (46'd1 << (sh - 6'd1));
		y_nx = (n_s[obvl_pkg::POW_STAGES] >= 9'd32) ? '0 : 17'(sum >> sh);
	end

	always_ff @(posedge clk) begin
		if (en) y_q <= y_nx;
	end

	assign y = y_q;

endmodule

/* hw/rtl/omni_base_velocity_law_core.sv */
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// input     in_valid / in_stall      distance_to_target, heading_error, road_curvature,
//                                    dir_x, dir_z, road_finished, needs_replanning, robot_lost
// output    out_valid / out_stall    side_speed, advance_speed, rotation_speed, stopped
// config    APB (psel..pready)       max_advance_speed at byte address 0
//
// 28-stage pipeline, one item per cycle while the output is not stalled.
// Most of the depth is the 5-stage divider followed by the 17-stage 2^-x units.
// The whole pipeline holds while the output register is full and stalled.
// Reset clears the valid bits and loads max_advance_speed with 300.

module omni_base_velocity_law_core (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        distance_to_target,
	input  logic signed [14:0] heading_error,
	input  logic signed [15:0] road_curvature,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_z,
	input  logic               road_finished,
	input  logic               needs_replanning,
	input  logic               robot_lost,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [11:0] side_speed,
	output logic signed [11:0] advance_speed,
	output logic signed [13:0] rotation_speed,
	output logic               stopped,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int N = obvl_pkg::PIPE_DEPTH;

	logic                  en;
	logic [10:0]           mas_q;
	logic                  vld_s  [1:N];
	obvl_pkg::side_t       side_s [1:N-1];
	logic [15:0]           dist_s1;
	logic [15:0]           acurv_s1;
	logic [21:0]           xc_s   [2:6];
	logic [21:0]           xr_s   [2:6];
	logic [24:0]           quot;
	logic [16:0]           fc, fd_raw, fr;
	logic [26:0]           mod_s24, mod_s25, mod_s26;
	logic [16:0]           fd_s24, fr_s24, fr_s25;
	logic [13:0]           px_s27, pz_s27;
	logic signed [11:0]    side_s28, adv_s28;
	logic signed [13:0]    rot_s28;
	logic                  stop_s28;
	obvl_pkg::side_t       side_in;
	logic signed [14:0]    h_adj;
	logic [13:0]           arot;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == obvl_pkg::REG_MAX_ADV) ? 32'(mas_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mas_q <= obvl_pkg::MAX_ADV_RESET;
		end else if (psel && penable && pwrite && paddr[2] == obvl_pkg::REG_MAX_ADV) begin
			mas_q <= pwdata[10:0];
		end
	end

	// pipeline advances unless the output transaction is held
	assign en       = !(vld_s[N] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= N; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= N; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// stage 1: decode flags, halve heading (zero unless beyond DIST_NEAR), curvature magnitude
	assign h_adj = heading_error + $signed({14'b0, heading_error[14]});

	always_comb begin
		side_in.abort_f = road_finished | needs_replanning | robot_lost;
		side_in.rot     = (distance_to_target > obvl_pkg::DIST_NEAR) ? h_adj[14:1] : '0;
		side_in.dx      = dir_x;
		side_in.dz      = dir_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= side_in;
			for (int i = 2; i <= N-1; i++) side_s[i] <= side_s[i-1];
			dist_s1  <= distance_to_target;
			acurv_s1 <= road_curvature[15] ? 16'(-road_curvature) : 16'(road_curvature);
		end
	end

	// stage 2: exponents in Q16, then delay to meet the divider
	assign arot = side_s[1].rot[13] ? 14'(-side_s[1].rot) : 14'(side_s[1].rot);

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s[2] <= 22'((34'(acurv_s1) * 34'(obvl_pkg::CURV_K)) >> 12);
			xr_s[2] <= 22'((34'(arot) * 34'(obvl_pkg::ROT_K)) >> 12);
			for (int i = 3; i <= 6; i++) begin
				xc_s[i] <= xc_s[i-1];
				xr_s[i] <= xr_s[i-1];
			end
		end
	end

	// stages 2..6: 500/d in Q16
	obvl_div u_div (
		.clk  (clk),
		.en   (en),
		.den  (dist_s1),
		.quot (quot)
	);

	// stages 7..23: three 2^-x factors
	obvl_pow2 u_pow_c (.clk(clk), .en(en), .x({3'b0, xc_s[6]}), .y(fc));
	obvl_pow2 u_pow_d (.clk(clk), .en(en), .x(quot),             .y(fd_raw));
	obvl_pow2 u_pow_r (.clk(clk), .en(en), .x({3'b0, xr_s[6]}), .y(fr));

	// stages 24..26: modulus chain
	always_ff @(posedge clk) begin
		if (en) begin
			mod_s24 <= obvl_pkg::mul_q16({mas_q, 16'b0}, fc);
			fd_s24  <= (fd_raw < obvl_pkg::FLOOR_TENTH) ? obvl_pkg::FLOOR_TENTH : fd_raw;
			fr_s24  <= fr;
			mod_s25 <= obvl_pkg::mul_q16(mod_s24, fd_s24);
			fr_s25  <= fr_s24;
			mod_s26 <= obvl_pkg::mul_q16(mod_s25, fr_s25);
		end
	end

	// stage 27: speed products
	always_ff @(posedge clk) begin
		if (en) begin
			px_s27 <= obvl_pkg::spd_mag(mod_s26, side_s[26].dx);
			pz_s27 <= obvl_pkg::spd_mag(mod_s26, side_s[26].dz);
		end
	end

	// stage 28: saturate, abort override, output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s[27].abort_f) begin
				side_s28 <= '0;
				adv_s28  <= '0;
				rot_s28  <= '0;
				stop_s28 <= 1'b1;
			end else begin
				side_s28 <= obvl_pkg::spd_final(px_s27, side_s[27].dx);
				adv_s28  <= obvl_pkg::spd_final(pz_s27, side_s[27].dz);
				rot_s28  <= side_s[27].rot;
				stop_s28 <= 1'b0;
			end
		end
	end

	assign out_valid      = vld_s[N];
	assign side_speed     = side_s28;
	assign advance_speed  = adv_s28;
	assign rotation_speed = rot_s28;
	assign stopped        = stop_s28;

endmodule

/* test/obvl_checker.sv */
`timescale 1ns / 1ps

module obvl_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [15:0]        distance_to_target,
	input  logic signed [14:0] heading_error,
	input  logic signed [15:0] road_curvature,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_z,
	input  logic               road_finished,
	input  logic               needs_replanning,
	input  logic               robot_lost,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [11:0] side_speed,
	input  logic signed [11:0] advance_speed,
	input  logic signed [13:0] rotation_speed,
	input  logic               stopped,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic signed [11:0] side;
		logic signed [11:0] adv;
		logic signed [13:0] rot;
		logic               stop;
	} speed_cmd_t;

	speed_cmd_t cmd_q[$];
	logic [10:0] speed_cap;
	logic [63:0] halving[1:16];

	// 2^-(2^-k) in Q30, by repeated square roots
	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] x, r, b;
		x = v;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	initial begin
		logic [63:0] c;
		c = 64'd1 << 29;
		for (int k = 1; k <= 16; k++) begin
			c = root64(c << 30);
			halving[k] = c;
		end
	end

	// 2^-x, x in Q16 -> Q16
	function automatic logic [63:0] exp2_neg(input logic [63:0] x);
		logic [63:0] n, r;
		int s;
		n = x >> 16;
		r = 64'd1 << 30;
		if (n >= 32) return 0;
		for (int k = 1; k <= 16; k++)
			if (x[16-k]) r = (r * halving[k]) >> 30;
		s = 14 + int'(n);
		return (r + (64'd1 << (s - 1))) >> s;
	endfunction

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		return (a * b + 64'd32768) >> 16;
	endfunction

	function automatic logic signed [11:0] axis_speed(input logic [63:0] m,
		input logic signed [15:0] d);
		logic [63:0] mag, p;
		longint v;
		mag = d < 0 ? 64'(-longint'(d)) : 64'(d);
		p = (m * mag + (64'd1 << 29)) >> 30;
		v = p > 4096 ? 4096 : longint'(p);
		if (d > 0) v = -v;
		if (v > 2000) v = 2000;
		if (v < -2000) v = -2000;
		return 12'(v);
	endfunction

	function automatic speed_cmd_t predict_cmd();
		speed_cmd_t c;
		longint rot, acv, arot;
		logic [63:0] fc, fd, fr, m;
		c = '0;
		if (road_finished | needs_replanning | robot_lost) begin
			c.stop = 1'b1;
			return c;
		end
		rot = distance_to_target > 500 ? longint'(heading_error) / 2 : 0;
		acv = road_curvature < 0 ? -longint'(road_curvature) : longint'(road_curvature);
		fc = exp2_neg((64'(acv) * 151278) >> 12);
		if (distance_to_target == 0) begin
			fd = 6554;
		end else begin
			fd = exp2_neg((64'd500 << 16) / distance_to_target);
			if (fd < 6554) fd = 6554;
		end
		arot = rot < 0 ? -rot : rot;
		fr = exp2_neg((64'(arot) * 725686) >> 12);
		m = 64'(speed_cap) << 16;
		m = qmul(qmul(qmul(m, fc), fd), fr);
		c.side = axis_speed(m, dir_x);
		c.adv = axis_speed(m, dir_z);
		c.rot = 14'(rot);
		return c;
	endfunction

	assign pending = cmd_q.size();

	// Shadow register, prediction on input, compare on output
	always @(posedge clk or negedge arst_n) begin
		speed_cmd_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			speed_cap <= obvl_pkg::MAX_ADV_RESET;
			fail_count <= 0;
			cmd_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == obvl_pkg::REG_MAX_ADV)
				speed_cap <= pwdata[10:0];
			if (in_valid && !in_stall) cmd_q.insert(cmd_q.size(), predict_cmd());
			if (out_valid && !out_stall) begin
				if (cmd_q.size() == 0) begin
					$error("unexpected result transaction");
					errs++;
				end else begin
					e = cmd_q.pop_front();
					if (e.side !== side_speed) begin
						$error("side_speed exp %0d got %0d", e.side, side_speed);
						errs++;
					end
					if (e.adv !== advance_speed) begin
						$error("advance_speed exp %0d got %0d", e.adv, advance_speed);
						errs++;
					end
					if (e.rot !== rotation_speed) begin
						$error("rotation_speed exp %0d got %0d", e.rot, rotation_speed);
						errs++;
					end
					if (e.stop !== stopped) begin
						$error("stopped exp %0d got %0d", e.stop, stopped);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule

/* test/tb_omni_base_velocity_law_core.sv */
`timescale 1ns / 1ps

module tb_omni_base_velocity_law_core;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [15:0] distance_to_target = 0;
	logic signed [14:0] heading_error = 0;
	logic signed [15:0] road_curvature = 0, dir_x = 0, dir_z = 0;
	logic road_finished = 0, needs_replanning = 0, robot_lost = 0;
	logic signed [11:0] side_speed, advance_speed;
	logic signed [13:0] rotation_speed;
	logic stopped;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	int fail_count, pending;
	int rx_hold = 0;
	bit rx_quiet = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	omni_base_velocity_law_core i_dut (.*);
	obvl_checker i_chk (.*);

	task automatic cap_write(input logic [31:0] v);
		@(posedge clk);
		psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_meas(input logic [15:0] d, input logic [14:0] h,
		input logic [15:0] c, input logic [15:0] x, input logic [15:0] z,
		input logic [2:0] flags, input bit lazy);
		int gap;
		gap = lazy ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		distance_to_target <= d; heading_error <= h; road_curvature <= c;
		dir_x <= x; dir_z <= z;
		{road_finished, needs_replanning, robot_lost} <= flags;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (obvl_pkg::PIPE_DEPTH + 4) @(posedge clk);
	endtask

	// Receiver stall: per-result wait draw, with quiet phases
	always @(posedge clk) begin
		int draw;
		if (rx_quiet) begin
			out_stall <= 0;
			rx_hold <= 0;
		end else if (out_valid && !out_stall) begin
			draw = $urandom_range(0, 14);
			out_stall <= (draw != 0);
			rx_hold <= draw;
		end else if (out_stall) begin
			out_stall <= (rx_hold > 1);
			rx_hold <= rx_hold - 1;
		end
	end

	task automatic rand_meas(input bit lazy);
		logic [15:0] d, x, z;
		int sel;
		sel = $urandom_range(0, 9);
		d = sel < 3 ? 16'($urandom_range(0, 1200)) : 16'($urandom);
		x = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
		z = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
		send_meas(d, 15'($urandom), ($urandom_range(0, 2) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 4000) - 2000), x, z,
			($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd0, lazy);
	endtask

	initial begin
		logic [31:0] caps[5];
		caps = '{32'd0, 32'd2000, 32'd2047, 32'd1, 32'd777};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: extremes, abort flags, zero / near distance
		send_meas(0, 0, 0, 16'sd16384, 16'sd0, 0, 0);
		send_meas(500, 15'sd12868, 0, 16'sd0, -16'sd16384, 0, 0);
		send_meas(501, -15'sd12868, 0, -16'sd16384, 16'sd16384, 0, 0);
		send_meas(65535, 15'sd1, 16'sh7fff, 16'sd16384, 16'sd16384, 0, 0);
		send_meas(65535, 15'sh4000, 16'sh8000, 16'sh7fff, 16'sh8000, 0, 0);
		send_meas(65535, 15'sh3fff, 0, 16'sh8000, 16'sh7fff, 0, 0);
		send_meas(1000, 0, 0, 16'sd1, -16'sd1, 0, 0);
		send_meas(1000, 0, 0, 16'sd16384, 16'sd0, 3'b100, 0);
		send_meas(1000, 0, 0, 16'sd16384, 16'sd0, 3'b010, 0);
		send_meas(1000, 0, 0, 16'sd16384, 16'sd0, 3'b001, 0);
		send_meas(1, 0, 0, 16'sd16384, 16'sd16384, 3'b111, 0);
		drain();
		cap_write(32'd2047);
		send_meas(65535, 0, 0, 16'sh7fff, 16'sh8000, 0, 0);
		send_meas(20000, 0, 0, 16'sd16384, -16'sd16384, 0, 0);
		drain();
		// Random phases across register settings
		foreach (caps[p]) begin
			cap_write(caps[p]);
			rx_quiet = (p == 1);
			for (int i = 0; i < 390; i++) rand_meas(p != 1);
			drain();
		end
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule

/* omni_base_velocity_law_core.f */
hw/rtl/obvl_pkg.sv
hw/rtl/obvl_div.sv
hw/rtl/obvl_pow2.sv
hw/rtl/omni_base_velocity_law_core.sv
test/obvl_checker.sv
test/tb_omni_base_velocity_law_core.sv
